// ----- sv/iokt_pkg.sv -----
`default_nettype none
package iokt_pkg;
  localparam int CAPACITY   = 16;
  localparam int SLOT_BITS  = $clog2(CAPACITY);
  localparam int LINK_BITS  = $clog2(CAPACITY + 1);
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam logic [LINK_BITS-1:0] NONE_SLOT = LINK_BITS'(CAPACITY);

  localparam logic [2:0] OP_PUT      = 3'd0;
  localparam logic [2:0] OP_GET      = 3'd1;
  localparam logic [2:0] OP_REMOVE   = 3'd2;
  localparam logic [2:0] OP_CONTAINS = 3'd3;
  localparam logic [2:0] OP_LIST     = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_SCAN_WAIT, ST_DECIDE, ST_LINK_A, ST_LINK_B,
    ST_LIST_RD, ST_LIST_WAIT, ST_EMIT
  } state_t;
endpackage
`default_nettype wire

// ----- sv/insertion_ordered_key_table.sv -----
// Insertion-ordered key/value table, 16 slots.
// Input channel: in_valid/in_stall with in_kind, in_key, in_value. Kinds are
// put, get, remove, contains and list; other kinds echo the key.
// Result channel: out_valid/out_stall with out_result_key, out_result_value,
// out_found, out_full_error, out_entry_count, out_last. Every item gives one
// result except list, which gives one per stored entry in insertion order
// (or one empty marker), out_last set on the final one.
// Keys are searched serially through all slots of the key memory (one read
// port, registered read); a list walks the next-link memory entry by entry.
// One item is in flight at a time; in_stall is high until the block is idle.
// The result sits in an output register; while out_stall is high the block
// holds it, and a following item is taken and worked up to its first result.
// Reset (rst_n low, synchronous) clears the used bits, head, tail and count.
// Memory contents are not cleared and need no clearing pass.
`default_nettype none
module insertion_ordered_key_table
  import iokt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [2:0]            in_kind,
  input  wire logic [KEY_BITS-1:0]   in_key,
  input  wire logic signed [VALUE_BITS-1:0] in_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [KEY_BITS-1:0]        out_result_key,
  output logic signed [VALUE_BITS-1:0] out_result_value,
  output logic                       out_found,
  output logic                       out_full_error,
  output logic [4:0]                 out_entry_count,
  output logic                       out_last
);
  logic [KEY_BITS-1:0]   key_mem  [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem  [CAPACITY];
  logic [LINK_BITS-1:0]  next_mem [CAPACITY];
  logic [LINK_BITS-1:0]  prev_mem [CAPACITY];
  logic [CAPACITY-1:0]   used_r, used_nxt;

  state_t state_r, state_nxt;
  logic [2:0]            kind_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [LINK_BITS-1:0]  first_r, first_nxt, final_r, final_nxt;
  logic [4:0]            count_r, count_nxt;
  logic [LINK_BITS-1:0]  idx_r, idx_nxt;     // scan pointer / list cursor
  logic [LINK_BITS-1:0]  hit_r, hit_nxt;
  logic                  added_r, added_nxt;
  logic [4:0]            nlist_r, nlist_nxt;
  logic [SLOT_BITS-1:0]  ridx_r;
  logic                  rvld_r;
  logic [KEY_BITS-1:0]   rkey_q;
  logic [VALUE_BITS-1:0] rval_q;
  logic [LINK_BITS-1:0]  rnext_q, rprev_q;

  // Output register
  logic                  ov_r;
  logic [KEY_BITS-1:0]   ok_r;
  logic [VALUE_BITS-1:0] ovl_r;
  logic                  of_r, oe_r, ol_r;
  logic [4:0]            oc_r;

  // Memory access controls
  logic                  rd_en;
  logic [SLOT_BITS-1:0]  rd_addr;
  logic                  kv_we;
  logic [SLOT_BITS-1:0]  kv_addr;
  logic                  key_we;
  logic                  na_we, nb_we, pa_we, pb_we;
  logic [SLOT_BITS-1:0]  na_addr, nb_addr, pa_addr, pb_addr;
  logic [LINK_BITS-1:0]  na_d, nb_d, pa_d, pb_d;

  logic                  emit;
  logic [KEY_BITS-1:0]   ek;
  logic [VALUE_BITS-1:0] ev;
  logic                  ef, ee, el;

  logic                  free_ok;
  logic [SLOT_BITS-1:0]  free_slot;

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_result_key = ok_r;
  assign out_result_value = ovl_r;
  assign out_found = of_r;
  assign out_full_error = oe_r;
  assign out_entry_count = oc_r;
  assign out_last = ol_r;

  // Lowest free slot
  always_comb begin
    free_ok = 1'b0;
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_ok = 1'b1;
        free_slot = SLOT_BITS'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rkey_q  <= key_mem[rd_addr];
      rval_q  <= val_mem[rd_addr];
      rnext_q <= next_mem[rd_addr];
      rprev_q <= prev_mem[rd_addr];
    end
    if (key_we) key_mem[kv_addr] <= key_r;
    if (kv_we)  val_mem[kv_addr] <= val_r;
    if (na_we)  next_mem[na_addr] <= na_d;
    if (nb_we)  next_mem[nb_addr] <= nb_d;
    if (pa_we)  prev_mem[pa_addr] <= pa_d;
    if (pb_we)  prev_mem[pb_addr] <= pb_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r  <= '0;
      first_r <= NONE_SLOT;
      final_r <= NONE_SLOT;
      count_r <= '0;
      ov_r    <= 1'b0;
      rvld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      first_r <= first_nxt;
      final_r <= final_nxt;
      count_r <= count_nxt;
      rvld_r  <= rd_en && (state_r == ST_SCAN);
      if (emit) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid && !in_stall) begin
      kind_r <= in_kind;
      key_r  <= in_key;
      val_r  <= in_value;
    end
    idx_r   <= idx_nxt;
    hit_r   <= hit_nxt;
    added_r <= added_nxt;
    nlist_r <= nlist_nxt;
    ridx_r  <= rd_addr;
    if (emit) begin
      ok_r  <= ek;
      ovl_r <= ev;
      of_r  <= ef;
      oe_r  <= ee;
      ol_r  <= el;
      oc_r  <= count_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          if (in_kind == OP_LIST) state_nxt = ST_LIST_RD;
          else if (in_kind <= OP_CONTAINS) state_nxt = ST_SCAN;
          else state_nxt = ST_EMIT;
        end
      end
      ST_SCAN: if (idx_r == LINK_BITS'(CAPACITY - 1)) state_nxt = ST_SCAN_WAIT;
      ST_SCAN_WAIT: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (hit_r != NONE_SLOT) begin
          state_nxt = (kind_r == OP_GET) ? ST_LIST_WAIT :
                      (kind_r == OP_REMOVE) ? ST_LINK_A : ST_EMIT;
        end else if (kind_r == OP_PUT && free_ok) state_nxt = ST_LINK_A;
        else state_nxt = ST_EMIT;
      end
      ST_LINK_A: state_nxt = ST_LINK_B;
      ST_LINK_B: state_nxt = ST_EMIT;
      ST_LIST_RD: begin
        if (ov_r && out_stall) state_nxt = ST_LIST_RD;
        else if (kind_r != OP_LIST) state_nxt = ST_EMIT;
        else if (idx_r == NONE_SLOT || nlist_r == 5'(CAPACITY)) state_nxt = ST_EMIT;
        else state_nxt = ST_LIST_WAIT;
      end
      ST_LIST_WAIT: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (ov_r && out_stall) state_nxt = ST_EMIT;
        else if (kind_r == OP_LIST && !el) state_nxt = ST_LIST_RD;
        else state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    logic [SLOT_BITS-1:0] h;
    logic [SLOT_BITS-1:0] ps, ns;
    h = hit_r[SLOT_BITS-1:0];
    ps = rprev_q[SLOT_BITS-1:0];
    ns = rnext_q[SLOT_BITS-1:0];
    used_nxt = used_r;
    first_nxt = first_r;
    final_nxt = final_r;
    count_nxt = count_r;
    idx_nxt = idx_r;
    hit_nxt = hit_r;
    added_nxt = added_r;
    nlist_nxt = nlist_r;
    rd_en = 1'b0;
    rd_addr = ridx_r;
    kv_we = 1'b0;
    key_we = 1'b0;
    kv_addr = h;
    na_we = 1'b0; nb_we = 1'b0; pa_we = 1'b0; pb_we = 1'b0;
    na_addr = '0; nb_addr = '0; pa_addr = '0; pb_addr = '0;
    na_d = NONE_SLOT; nb_d = NONE_SLOT; pa_d = NONE_SLOT; pb_d = NONE_SLOT;
    emit = 1'b0;
    ek = key_r; ev = '0; ef = 1'b0; ee = 1'b0; el = 1'b1;

    // Compare a key read from the previous scan cycle
    if (rvld_r && used_r[ridx_r] && rkey_q == key_r) hit_nxt = {1'b0, ridx_r};

    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        hit_nxt = NONE_SLOT;
        added_nxt = 1'b0;
        nlist_nxt = '0;
        if (in_valid && !in_stall && in_kind == OP_LIST) idx_nxt = first_r;
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        rd_addr = idx_r[SLOT_BITS-1:0];
        idx_nxt = idx_r + 1'b1;
      end
      ST_SCAN_WAIT: ;
      ST_DECIDE: begin
        if (hit_r != NONE_SLOT) begin
          rd_en = 1'b1;
          rd_addr = h;
          if (kind_r == OP_PUT) begin
            kv_we = 1'b1;
          end
        end else if (kind_r == OP_PUT && free_ok) begin
          hit_nxt = {1'b0, free_slot};
        end
      end
      ST_LINK_A: begin
        if (kind_r == OP_PUT) begin
          key_we = 1'b1;
          kv_we = 1'b1;
          added_nxt = 1'b1;
          used_nxt[h] = 1'b1;
          pa_we = 1'b1; pa_addr = h; pa_d = final_r;
          na_we = 1'b1; na_addr = h; na_d = NONE_SLOT;
          if (final_r != NONE_SLOT) begin
            nb_we = 1'b1; nb_addr = final_r[SLOT_BITS-1:0]; nb_d = hit_r;
          end else first_nxt = hit_r;
          final_nxt = hit_r;
          count_nxt = count_r + 1'b1;
        end else begin
          // Remove: links were read in the decide cycle
          used_nxt[h] = 1'b0;
          if (rprev_q != NONE_SLOT) begin
            na_we = 1'b1; na_addr = ps; na_d = rnext_q;
          end else first_nxt = rnext_q;
          if (rnext_q != NONE_SLOT) begin
            pa_we = 1'b1; pa_addr = ns; pa_d = rprev_q;
          end else final_nxt = rprev_q;
          if (count_r != 0) count_nxt = count_r - 1'b1;
        end
      end
      ST_LINK_B: begin
        if (kind_r == OP_REMOVE) begin
          nb_we = 1'b1; nb_addr = h; nb_d = NONE_SLOT;
          pb_we = 1'b1; pb_addr = h; pb_d = NONE_SLOT;
        end
      end
      ST_LIST_RD: begin
        if (!(ov_r && out_stall) && idx_r != NONE_SLOT && nlist_r != 5'(CAPACITY)) begin
          rd_en = 1'b1;
          rd_addr = idx_r[SLOT_BITS-1:0];
        end
      end
      ST_LIST_WAIT: ;
      ST_EMIT: begin
        if (!(ov_r && out_stall)) begin
          emit = 1'b1;
          if (kind_r == OP_LIST) begin
            if (idx_r == NONE_SLOT || nlist_r == 5'(CAPACITY)) begin
              ek = '0; ef = 1'b0; el = 1'b1;
              idx_nxt = NONE_SLOT;
            end else begin
              ek = rkey_q; ev = rval_q; ef = 1'b1;
              el = (rnext_q == NONE_SLOT) || (nlist_r + 1'b1 == 5'(CAPACITY));
              nlist_nxt = nlist_r + 1'b1;
              idx_nxt = el ? NONE_SLOT : rnext_q;
            end
          end else if (kind_r <= OP_CONTAINS) begin
            ef = (hit_r != NONE_SLOT) && !added_r;
            if (kind_r == OP_PUT && hit_r == NONE_SLOT) ee = 1'b1;
            if (kind_r == OP_GET && ef) ev = rval_q;
            if (kind_r == OP_REMOVE) ef = (hit_r != NONE_SLOT);
          end
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire
